@@ design/mpdf_pkg.sv @@
// Shared types and constants of the mesh packet duplicate filter.
package mpdf_pkg;

	// Header layout and frame byte counter.
	localparam int HEADER_BYTES = 6;
	localparam int POS_W        = 9;
	localparam int HASH_W       = 32;
	localparam int ADDR_W       = 16;

	// Depth of the job queue between the parser and the cache engine.
	localparam int QUEUE_DEPTH  = 4;
	localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

	// Verdict codes.
	localparam logic [2:0] VERDICT_MALFORMED = 3'd0;
	localparam logic [2:0] VERDICT_DUPLICATE = 3'd1;
	localparam logic [2:0] VERDICT_LOCAL     = 3'd2;
	localparam logic [2:0] VERDICT_FORWARD   = 3'd3;
	localparam logic [2:0] VERDICT_OWN_SEND  = 3'd4;

	typedef struct packed {
		logic       command;
		logic [7:0] rx_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        verdict;
		logic [ADDR_W-1:0] dest_address;
		logic [ADDR_W-1:0] source_address;
		logic [7:0]        channel_offset;
		logic [7:0]        payload_length;
		logic [HASH_W-1:0] msg_hash;
	} out_item_t;

	// Kind of work handed from the parser to the cache engine.
	typedef enum logic [1:0] {
		JOB_FRAME,
		JOB_OWN,
		JOB_MALFORMED
	} job_kind_t;

	typedef struct packed {
		job_kind_t kind;
		logic      is_local;
		out_item_t item;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

@@ design/mesh_packet_dedup_filter_unit.sv @@
// Top level of the mesh packet duplicate filter: node address register and datapath.
//
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  mpdf_pkg::in_item_t (command, rx_byte, last_byte)
// out      output     out_valid/out_stall mpdf_pkg::out_item_t (verdict and parsed fields)
// cfg      input      cfg_valid/cfg_ready cfg_data, node address
//
// The parser takes one byte or own-send command per cycle while the job queue has room.
// A finished frame is searched for in the cache engine, which reads one ring entry per
// cycle through its single memory read port; an own send or a malformed frame skips
// the search and goes straight to the result. Reset clears the ring through a fill count,
// so no clearing pass is needed. A stalled output holds its result while the parser
// keeps accepting bytes until the queue of four jobs is full.
module mesh_packet_dedup_filter_unit #(
	parameter int CACHE_ENTRIES = 50,
	parameter int MAX_PAYLOAD   = 255
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  mpdf_pkg::in_item_t            in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output mpdf_pkg::out_item_t           out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mpdf_pkg::ADDR_W-1:0]   cfg_data
);

	logic [mpdf_pkg::ADDR_W-1:0] node_address_q;
	logic                        push;
	mpdf_pkg::job_t              push_data;
	logic                        pop;
	mpdf_pkg::job_t              pop_data;
	mpdf_pkg::queue_status_t     q_status;

	// Node address register, always writable.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_address_q <= 16'h1002;
		end else if (cfg_valid) begin
			node_address_q <= cfg_data;
		end
	end

	mpdf_front #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.node_address (node_address_q),
		.push         (push),
		.push_data    (push_data),
		.q_status     (q_status)
	);

	mpdf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	mpdf_back #(
		.CACHE_ENTRIES (CACHE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_status  (q_status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

@@ design/mpdf_queue.sv @@
// Short job queue that decouples the frame parser from the cache engine.
module mpdf_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  mpdf_pkg::job_t         push_data,
	input  logic                   pop,
	output mpdf_pkg::job_t         pop_data,
	output mpdf_pkg::queue_status_t status
);

	mpdf_pkg::job_t                        slot_q [mpdf_pkg::QUEUE_DEPTH];
	logic [mpdf_pkg::QUEUE_PTR_W-1:0]      wr_ptr_q;
	logic [mpdf_pkg::QUEUE_PTR_W-1:0]      rd_ptr_q;
	logic [mpdf_pkg::QUEUE_CNT_W-1:0]      count_q;
	logic                                  do_push;
	logic                                  do_pop;

	// Pushes are refused when full, pops when empty.
	assign status.full  = (count_q == mpdf_pkg::QUEUE_CNT_W'(mpdf_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_data     = slot_q[rd_ptr_q];

	// Storage slots.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/mpdf_front.sv @@
// Frame parser: collects header bytes, runs the payload hash and issues jobs.
module mpdf_front #(
	parameter int MAX_PAYLOAD = 255
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  mpdf_pkg::in_item_t              in_data,
	input  logic [mpdf_pkg::ADDR_W-1:0]     node_address,
	output logic                            push,
	output mpdf_pkg::job_t                  push_data,
	input  mpdf_pkg::queue_status_t         q_status
);

	localparam logic [mpdf_pkg::POS_W-1:0] POS_LIMIT =
		mpdf_pkg::POS_W'(mpdf_pkg::HEADER_BYTES + MAX_PAYLOAD);
	localparam logic [mpdf_pkg::POS_W-1:0] POS_HEADER =
		mpdf_pkg::POS_W'(mpdf_pkg::HEADER_BYTES);

	logic [mpdf_pkg::POS_W-1:0]  pos_q, pos_n;
	logic [mpdf_pkg::HASH_W-1:0] hash_q, hash_n;
	logic [mpdf_pkg::ADDR_W-1:0] dest_q, dest_n;
	logic [mpdf_pkg::ADDR_W-1:0] src_q, src_n;
	logic [7:0]                  offset_q, offset_n;
	logic [mpdf_pkg::ADDR_W-1:0] own_cnt_q;
	logic                        accept;

	// Every transaction may produce a job, so a full queue holds the input.
	assign in_stall = q_status.full;
	assign accept   = in_valid && !q_status.full;
	assign push     = accept && (in_data.command || in_data.last_byte);

	// Next frame state for a received byte.
	always_comb begin
		pos_n    = pos_q;
		hash_n   = hash_q;
		dest_n   = dest_q;
		src_n    = src_q;
		offset_n = offset_q;
		case (pos_q)
			mpdf_pkg::POS_W'(0): dest_n = {in_data.rx_byte, 8'h00};
			mpdf_pkg::POS_W'(1): dest_n = {dest_q[15:8], in_data.rx_byte};
			mpdf_pkg::POS_W'(2): offset_n = in_data.rx_byte;
			mpdf_pkg::POS_W'(3): src_n = {in_data.rx_byte, 8'h00};
			mpdf_pkg::POS_W'(4): begin
				src_n  = {src_q[15:8], in_data.rx_byte};
				hash_n = {16'h0000, src_q[15:8], in_data.rx_byte};
			end
			mpdf_pkg::POS_W'(5): begin
				hash_n = hash_q;
			end
			default: begin
				// hash * 31 + byte, as a shift and subtract.
				if (pos_q < POS_LIMIT) begin
					hash_n = (hash_q << 5) - hash_q + {24'h000000, in_data.rx_byte};
				end
			end
		endcase
		if (pos_q < POS_LIMIT) begin
			pos_n = pos_q + 1'b1;
		end
	end

	// Job contents for an own send or a finished frame.
	always_comb begin
		push_data = '0;
		if (in_data.command) begin
			push_data.kind                = mpdf_pkg::JOB_OWN;
			push_data.item.source_address = node_address;
			push_data.item.msg_hash       = {own_cnt_q, node_address};
		end else if (pos_n < POS_HEADER) begin
			push_data.kind = mpdf_pkg::JOB_MALFORMED;
		end else begin
			push_data.kind                = mpdf_pkg::JOB_FRAME;
			push_data.is_local            = (dest_n == node_address);
			push_data.item.dest_address   = dest_n;
			push_data.item.source_address = src_n;
			push_data.item.channel_offset = offset_n;
			push_data.item.payload_length = 8'(pos_n - POS_HEADER);
			push_data.item.msg_hash       = hash_n;
		end
	end

	// Frame state and own message counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			hash_q    <= '0;
			dest_q    <= '0;
			src_q     <= '0;
			offset_q  <= '0;
			own_cnt_q <= '0;
		end else if (accept) begin
			if (in_data.command) begin
				own_cnt_q <= own_cnt_q + 1'b1;
			end else if (in_data.last_byte) begin
				pos_q    <= '0;
				hash_q   <= '0;
				dest_q   <= '0;
				src_q    <= '0;
				offset_q <= '0;
			end else begin
				pos_q    <= pos_n;
				hash_q   <= hash_n;
				dest_q   <= dest_n;
				src_q    <= src_n;
				offset_q <= offset_n;
			end
		end
	end

endmodule

@@ design/mpdf_back.sv @@
// Cache engine: searches the ring of recent hashes, inserts misses and own sends, drives results.
module mpdf_back #(
	parameter int CACHE_ENTRIES = 50
) (
	input  logic                     clk,
	input  logic                     arst_n,
	output logic                     pop,
	input  mpdf_pkg::job_t           pop_data,
	input  mpdf_pkg::queue_status_t  q_status,
	output logic                     out_valid,
	input  logic                     out_stall,
	output mpdf_pkg::out_item_t      out_data
);

	localparam int IDX_W  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int FILL_W = $clog2(CACHE_ENTRIES + 1);
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);
	localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(CACHE_ENTRIES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EMIT
	} state_t;

	state_t                       state_q;
	mpdf_pkg::job_t               job_q;
	logic                         hit_q;
	logic [IDX_W-1:0]             search_idx_q;
	logic [IDX_W-1:0]             cmp_idx_s1;
	logic                         cmp_live_s1;
	logic [mpdf_pkg::HASH_W-1:0]  rd_data_s1;
	logic [IDX_W-1:0]             ins_pos_q;
	logic [FILL_W-1:0]            fill_q;
	logic                         out_valid_q;
	mpdf_pkg::out_item_t          out_q;
	logic [mpdf_pkg::HASH_W-1:0]  ring_mem [CACHE_ENTRIES];

	logic                         out_free;
	logic                         do_insert;
	logic [mpdf_pkg::HASH_W-1:0]  entry_value;
	logic                         entry_hit;
	mpdf_pkg::out_item_t          emit_item;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = (state_q == ST_IDLE) && !q_status.empty;

	// Entries not yet written since reset read as zero.
	assign entry_value = (FILL_W'(cmp_idx_s1) < fill_q) ? rd_data_s1 : '0;
	assign entry_hit   = cmp_live_s1 && (entry_value == job_q.item.msg_hash);

	// A miss of a valid frame and every own send enter the ring.
	assign do_insert = (state_q == ST_EMIT) && out_free &&
		((job_q.kind == mpdf_pkg::JOB_OWN) ||
		 ((job_q.kind == mpdf_pkg::JOB_FRAME) && !hit_q));

	// Result contents with the verdict for the current job.
	always_comb begin
		emit_item = job_q.item;
		case (job_q.kind)
			mpdf_pkg::JOB_OWN: emit_item.verdict = mpdf_pkg::VERDICT_OWN_SEND;
			mpdf_pkg::JOB_FRAME: begin
				if (hit_q) begin
					emit_item.verdict = mpdf_pkg::VERDICT_DUPLICATE;
				end else if (job_q.is_local) begin
					emit_item.verdict = mpdf_pkg::VERDICT_LOCAL;
				end else begin
					emit_item.verdict = mpdf_pkg::VERDICT_FORWARD;
				end
			end
			default: emit_item.verdict = mpdf_pkg::VERDICT_MALFORMED;
		endcase
	end

	// Hash ring: one write port at the insert position, one registered read port.
	always_ff @(posedge clk) begin
		if (do_insert) begin
			ring_mem[ins_pos_q] <= job_q.item.msg_hash;
		end
		rd_data_s1 <= ring_mem[search_idx_q];
	end

	// Job sequencer with the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			ins_pos_q    <= '0;
			fill_q       <= '0;
			cmp_live_s1  <= 1'b0;
			search_idx_q <= '0;
			cmp_idx_s1   <= '0;
			hit_q        <= 1'b0;
			job_q        <= '0;
			out_q        <= '0;
		end else begin
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_status.empty) begin
						job_q        <= pop_data;
						hit_q        <= 1'b0;
						search_idx_q <= '0;
						cmp_live_s1  <= 1'b0;
						if (pop_data.kind == mpdf_pkg::JOB_FRAME) begin
							state_q <= ST_SEARCH;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_SEARCH: begin
					// Read one entry a cycle; compare the one read the cycle before.
					cmp_live_s1 <= 1'b1;
					cmp_idx_s1  <= search_idx_q;
					if (search_idx_q != LAST_IDX) begin
						search_idx_q <= search_idx_q + 1'b1;
					end
					if (entry_hit) begin
						hit_q   <= 1'b1;
						state_q <= ST_EMIT;
					end else if (cmp_live_s1 && (cmp_idx_s1 == LAST_IDX)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_q <= emit_item;
						if (do_insert) begin
							ins_pos_q <= (ins_pos_q == LAST_IDX) ? '0 : ins_pos_q + 1'b1;
							if (fill_q != FULL_FILL) begin
								fill_q <= fill_q + 1'b1;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ tb/sv/mesh_packet_dedup_filter_unit_test.sv @@
// Self-checking testbench for the mesh packet duplicate filter top level.
`timescale 1ns / 1ps

module mesh_packet_dedup_filter_unit_test;

	localparam int RING_SIZE     = 50;
	localparam int PAYLOAD_MAX   = 255;
	localparam int FRAME_END_POS = mpdf_pkg::HEADER_BYTES + PAYLOAD_MAX;
	localparam int MAX_GAP       = 16;
	localparam int SETTLE_CYCLES = 2 * (RING_SIZE + 4) + 16;
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int RANDOM_ITEMS  = 800;
	localparam int PHASE_ITEMS   = 250;
	localparam int HISTORY_SLOTS = 16;
	localparam int HISTORY_BYTES = 40;

	localparam logic CMD_FRAME_BYTE = 1'b0;
	localparam logic CMD_OWN_SEND   = 1'b1;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	mpdf_pkg::in_item_t            in_data;
	logic                          out_valid;
	logic                          out_stall;
	mpdf_pkg::out_item_t           out_data;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [mpdf_pkg::ADDR_W-1:0]   cfg_data;

	mesh_packet_dedup_filter_unit #(
		.CACHE_ENTRIES(RING_SIZE),
		.MAX_PAYLOAD  (PAYLOAD_MAX)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// Predicted state of the filter.
	logic [mpdf_pkg::HASH_W-1:0] seen_model [RING_SIZE];
	int unsigned                 ring_slot;
	logic [mpdf_pkg::POS_W-1:0]  frame_pos;
	logic [mpdf_pkg::HASH_W-1:0] frame_hash;
	logic [mpdf_pkg::ADDR_W-1:0] frame_dest;
	logic [mpdf_pkg::ADDR_W-1:0] frame_src;
	logic [7:0]                  frame_offset;
	logic [mpdf_pkg::ADDR_W-1:0] own_count;
	logic [mpdf_pkg::ADDR_W-1:0] node_addr;

	// Verdicts still owed by the block, oldest first.
	mpdf_pkg::out_item_t pending_verdicts [$];

	int mismatch_count  = 0;
	int items_sent      = 0;
	int results_checked = 0;
	int cfg_writes      = 0;
	int own_sends       = 0;
	int verdict_count [8];
	int cycle_count     = 0;
	int in_gap_max      = MAX_GAP;
	int out_gap_max     = MAX_GAP;
	int hold_request    = 0;

	// Frame under construction and a history of short frames for replay.
	logic [7:0] frame_buf [$];
	logic [7:0] history_bytes [HISTORY_SLOTS][HISTORY_BYTES];
	int         history_len [HISTORY_SLOTS];
	int         history_fill = 0;
	int         history_wr   = 0;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on the total run length.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d verdicts outstanding", CYCLE_LIMIT,
			pending_verdicts.size());
		$display("Mismatches found");
		$finish;
	end

	function automatic int draw_gap(int max_gap);
		if (max_gap == 0 || $urandom_range(0, 2) != 0)
			return 0;
		return $urandom_range(0, max_gap);
	endfunction

	task automatic report_mismatch(string what);
		mismatch_count++;
		$display("MISMATCH at cycle %0d: %s", cycle_count, what);
	endtask

	task automatic compare_field(string name, logic [31:0] got_v, logic [31:0] want_v);
		if (got_v !== want_v)
			report_mismatch($sformatf("%s got %0h, expected %0h", name, got_v, want_v));
	endtask

	// Compare one accepted transaction with the oldest predicted verdict.
	task automatic check_result(mpdf_pkg::out_item_t got);
		mpdf_pkg::out_item_t want;
		if (pending_verdicts.size() == 0) begin
			report_mismatch($sformatf("unexpected result, verdict %0d hash %08h",
				got.verdict, got.msg_hash));
			return;
		end
		want = pending_verdicts.pop_front();
		results_checked++;
		verdict_count[want.verdict]++;
		compare_field("verdict", 32'(got.verdict), 32'(want.verdict));
		compare_field("dest_address", 32'(got.dest_address), 32'(want.dest_address));
		compare_field("source_address", 32'(got.source_address), 32'(want.source_address));
		compare_field("channel_offset", 32'(got.channel_offset), 32'(want.channel_offset));
		compare_field("payload_length", 32'(got.payload_length), 32'(want.payload_length));
		compare_field("msg_hash", got.msg_hash, want.msg_hash);
	endtask

	// Write a hash at the ring position and advance it.
	task automatic store_hash(logic [mpdf_pkg::HASH_W-1:0] h);
		if (ring_slot >= RING_SIZE)
			ring_slot = 0;
		seen_model[ring_slot] = h;
		ring_slot++;
		if (ring_slot >= RING_SIZE)
			ring_slot = 0;
	endtask

	// Advance the predicted state by one accepted input and queue any verdict.
	task automatic predict_verdict(mpdf_pkg::in_item_t item);
		mpdf_pkg::out_item_t         res;
		logic [mpdf_pkg::HASH_W-1:0] h;
		bit                          hit;
		res = '0;
		if (item.command == CMD_OWN_SEND) begin
			h = {own_count, node_addr};
			own_count++;
			own_sends++;
			store_hash(h);
			res.verdict        = mpdf_pkg::VERDICT_OWN_SEND;
			res.source_address = node_addr;
			res.msg_hash       = h;
			pending_verdicts.push_back(res);
			return;
		end

		// Header parse, then the payload hash until the payload limit.
		case (frame_pos)
			0: frame_dest = {item.rx_byte, 8'h00};
			1: frame_dest[7:0] = item.rx_byte;
			2: frame_offset = item.rx_byte;
			3: frame_src = {item.rx_byte, 8'h00};
			4: begin
				frame_src[7:0] = item.rx_byte;
				frame_hash = {16'h0000, frame_src[15:8], item.rx_byte};
			end
			5: ;
			default: begin
				if (frame_pos < FRAME_END_POS)
					frame_hash = frame_hash * 32'd31 + 32'(item.rx_byte);
			end
		endcase
		if (frame_pos < FRAME_END_POS)
			frame_pos++;
		if (!item.last_byte)
			return;

		// End of frame: malformed, duplicate, or a new hash for the ring.
		if (frame_pos < mpdf_pkg::HEADER_BYTES) begin
			res.verdict = mpdf_pkg::VERDICT_MALFORMED;
		end else begin
			h = frame_hash;
			hit = 1'b0;
			for (int i = 0; i < RING_SIZE; i++)
				if (seen_model[i] == h)
					hit = 1'b1;
			if (hit) begin
				res.verdict = mpdf_pkg::VERDICT_DUPLICATE;
			end else begin
				store_hash(h);
				res.verdict = (frame_dest == node_addr) ? mpdf_pkg::VERDICT_LOCAL
					: mpdf_pkg::VERDICT_FORWARD;
			end
			res.dest_address   = frame_dest;
			res.source_address = frame_src;
			res.channel_offset = frame_offset;
			res.payload_length = 8'(frame_pos - mpdf_pkg::HEADER_BYTES);
			res.msg_hash       = h;
		end
		pending_verdicts.push_back(res);
		frame_pos    = '0;
		frame_hash   = '0;
		frame_dest   = '0;
		frame_src    = '0;
		frame_offset = '0;
	endtask

	// Offer one transaction after a random gap and wait until it is taken.
	task automatic send_item(mpdf_pkg::in_item_t item);
		int gap;
		gap = draw_gap(in_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		items_sent++;
		predict_verdict(item);
	endtask

	task automatic send_own();
		mpdf_pkg::in_item_t item;
		item.command   = CMD_OWN_SEND;
		item.rx_byte   = 8'($urandom);
		item.last_byte = 1'($urandom);
		send_item(item);
	endtask

	// Send the frame buffer byte by byte, with own sends mixed in at random
	// or at one fixed byte position, and keep short frames for replay.
	task automatic send_frame(int own_pct, int own_at);
		mpdf_pkg::in_item_t item;
		for (int i = 0; i < frame_buf.size(); i++) begin
			if (i == own_at || (own_pct > 0 && $urandom_range(0, 99) < own_pct))
				send_own();
			item.command   = CMD_FRAME_BYTE;
			item.rx_byte   = frame_buf[i];
			item.last_byte = (i == frame_buf.size() - 1);
			send_item(item);
		end
		if (frame_buf.size() <= HISTORY_BYTES) begin
			for (int i = 0; i < frame_buf.size(); i++)
				history_bytes[history_wr][i] = frame_buf[i];
			history_len[history_wr] = frame_buf.size();
			history_wr = (history_wr + 1) % HISTORY_SLOTS;
			if (history_fill < HISTORY_SLOTS)
				history_fill++;
		end
	endtask

	task automatic build_frame(logic [mpdf_pkg::ADDR_W-1:0] dest,
		logic [mpdf_pkg::ADDR_W-1:0] src, int body_len);
		frame_buf.delete();
		frame_buf.push_back(dest[15:8]);
		frame_buf.push_back(dest[7:0]);
		frame_buf.push_back(8'($urandom));
		frame_buf.push_back(src[15:8]);
		frame_buf.push_back(src[7:0]);
		frame_buf.push_back(8'($urandom));
		repeat (body_len) frame_buf.push_back(8'($urandom));
	endtask

	// Stop offering, let every verdict arrive, then let the block settle.
	task automatic wait_until_idle();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_node_address(logic [mpdf_pkg::ADDR_W-1:0] addr);
		wait_until_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= addr;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		cfg_valid <= 1'b0;
		node_addr = addr;
		cfg_writes++;
	endtask

	// Receiver: check each accepted result and stall at random, or for a
	// long hold-off when one is requested.
	initial begin : result_monitor
		int stall_left;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				check_result(out_data);
				stall_left = draw_gap(out_gap_max);
			end
			if (hold_request > 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Reset address in an own send, and a zero hash hitting the cleared ring.
	task automatic test_reset_defaults();
		send_own();
		frame_buf = '{8'h10, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00};
		send_frame(0, -1);
	endtask

	// Frames that end before the header is complete.
	task automatic test_short_frames();
		frame_buf = '{8'hA5};
		send_frame(0, -1);
		frame_buf = '{8'h12, 8'h34, 8'h56, 8'h78, 8'h9A};
		send_frame(0, -1);
	endtask

	// Address register at both extremes, with an own send inside a frame.
	task automatic test_address_extremes();
		write_node_address(16'hFFFF);
		frame_buf = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF};
		send_frame(0, 3);
		write_node_address(16'h0000);
		send_own();
	endtask

	// Payloads around and beyond the payload limit.
	task automatic test_overlong_frames();
		int lens [4];
		lens = '{PAYLOAD_MAX - 1, PAYLOAD_MAX, PAYLOAD_MAX + 1, PAYLOAD_MAX + 40};
		foreach (lens[i]) begin
			build_frame(16'($urandom), 16'($urandom), lens[i]);
			send_frame(2, -1);
		end
	endtask

	// Long receiver hold-off while the sender keeps offering frames.
	task automatic test_backpressure();
		wait_until_idle();
		in_gap_max = 0;
		hold_request = 400;
		repeat (12) begin
			build_frame(16'($urandom), 16'($urandom), $urandom_range(0, 3));
			send_frame(0, -1);
		end
		wait_until_idle();
		in_gap_max = MAX_GAP;
	endtask

	// Mostly well-formed frames with random content, plus replays, noise,
	// long frames, own sends and address changes between phases.
	task automatic test_random_traffic();
		int                          start;
		int                          next_phase;
		int                          kind;
		int                          slot;
		logic [mpdf_pkg::ADDR_W-1:0] dest;
		start = items_sent;
		next_phase = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if (items_sent >= next_phase) begin
				next_phase = items_sent + PHASE_ITEMS;
				if ($urandom_range(0, 1) == 1)
					write_node_address(16'($urandom));
				in_gap_max  = ($urandom_range(0, 2) != 0) ? MAX_GAP : 0;
				out_gap_max = ($urandom_range(0, 2) != 0) ? MAX_GAP : 0;
			end
			kind = $urandom_range(0, 99);
			dest = ($urandom_range(0, 3) == 0) ? node_addr : 16'($urandom);
			if (kind < 6) begin
				send_own();
			end else if (kind < 14) begin
				frame_buf.delete();
				repeat ($urandom_range(1, mpdf_pkg::HEADER_BYTES - 1))
					frame_buf.push_back(8'($urandom));
				send_frame(5, -1);
			end else if (kind < 30 && history_fill > 0) begin
				slot = $urandom_range(0, history_fill - 1);
				frame_buf.delete();
				for (int i = 0; i < history_len[slot]; i++)
					frame_buf.push_back(history_bytes[slot][i]);
				send_frame(5, -1);
			end else if (kind < 32) begin
				build_frame(dest, 16'($urandom), $urandom_range(200, 280));
				send_frame(2, -1);
			end else if (kind < 35) begin
				build_frame(dest, 16'h0000, 0);
				send_frame(0, -1);
			end else begin
				build_frame(dest, 16'($urandom), $urandom_range(0, 24));
				send_frame(5, -1);
			end
			if ($urandom_range(0, 24) == 0)
				wait_until_idle();
		end
	endtask

	// Reset, tests in turn, drain and verdict.
	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		foreach (seen_model[i])
			seen_model[i] = '0;
		foreach (verdict_count[i])
			verdict_count[i] = 0;
		ring_slot    = 0;
		frame_pos    = '0;
		frame_hash   = '0;
		frame_dest   = '0;
		frame_src    = '0;
		frame_offset = '0;
		own_count    = '0;
		node_addr    = 16'h1002;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_short_frames();
		test_address_extremes();
		test_overlong_frames();
		test_backpressure();
		test_random_traffic();
		wait_until_idle();

		$display("Run covered %0d input transactions, %0d results, %0d own sends,",
			items_sent, results_checked, own_sends);
		$display("%0d address writes; verdicts: %0d malformed, %0d duplicate, %0d local, %0d forward.",
			cfg_writes,
			verdict_count[mpdf_pkg::VERDICT_MALFORMED], verdict_count[mpdf_pkg::VERDICT_DUPLICATE],
			verdict_count[mpdf_pkg::VERDICT_LOCAL], verdict_count[mpdf_pkg::VERDICT_FORWARD]);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ mesh_packet_dedup_filter_unit.f @@
design/mpdf_pkg.sv
design/mpdf_queue.sv
design/mpdf_front.sv
design/mpdf_back.sv
design/mesh_packet_dedup_filter_unit.sv
tb/sv/mesh_packet_dedup_filter_unit_test.sv
